/* rtl/lcs_pkg.sv */
// Shared types and constants for the LCS length engine.
// No dependencies; used by every other file in rtl/.
package lcs_pkg;

  // Default store depth for both strings.
  localparam int MAX_LEN_DEF = 64;

  // Fixed field widths of the request and result payloads.
  localparam int SYM_W = 8;
  localparam int LEN_W = 7;

  // Request operation codes.
  localparam logic OP_FIRST  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } lcs_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] match_length;
    logic             truncated;
  } lcs_out_t;

  // Control part of the token that walks the cell chain.
  typedef struct packed {
    logic             valid;
    logic             upd;
    logic [SYM_W-1:0] sym;
  } lcs_tok_t;

endpackage

/* rtl/lcs_cell.sv */
// One cell of the LCS chain: one first-string symbol and its DP entry.
// Depends on lcs_pkg.
module lcs_cell #(
  parameter int IDX     = 0,
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF,
  parameter int CNT_W   = $clog2(MAX_LEN + 1),
  parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_idx,
  input  logic [lcs_pkg::SYM_W-1:0] wr_sym,
  input  logic [CNT_W-1:0]         first_len,
  input  lcs_pkg::lcs_tok_t        tok_in,
  input  logic [CNT_W-1:0]         diag_in,
  input  logic [CNT_W-1:0]         left_in,
  output lcs_pkg::lcs_tok_t        tok_out,
  output logic [CNT_W-1:0]         diag_out,
  output logic [CNT_W-1:0]         left_out
);

  localparam logic [IDX_W-1:0] IDX_C = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] POS_C = CNT_W'(IDX);

  logic [lcs_pkg::SYM_W-1:0] char_r, char_nxt;
  logic [CNT_W-1:0]          val_r, val_nxt;
  logic [CNT_W-1:0]          diag_r, diag_nxt;
  logic [CNT_W-1:0]          left_r, left_nxt;
  lcs_pkg::lcs_tok_t         tok_r, tok_nxt;
  logic                      active;
  logic [CNT_W-1:0]          cand;

  assign active = POS_C < first_len;

  // match: diagonal + 1, else max(above, left)
  assign cand = (char_r == tok_in.sym) ? (diag_in + CNT_W'(1)) :
                ((val_r > left_in) ? val_r : left_in);

  always_comb begin
    char_nxt = char_r;
    val_nxt  = val_r;
    tok_nxt  = tok_in;
    diag_nxt = diag_in;
    left_nxt = left_in;
    if (wr_en && (wr_idx == IDX_C)) begin
      char_nxt = wr_sym;
    end
    if (tok_in.valid && active) begin
      if (tok_in.upd) begin
        val_nxt  = cand;
        left_nxt = cand;
        diag_nxt = val_r;
      end else begin
        left_nxt = val_r;  // read-only pass: report own entry
      end
    end
    if (clear) begin
      val_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      tok_r <= '0;
    end else begin
      val_r <= val_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    diag_r <= diag_nxt;
    left_r <= left_nxt;
  end

  assign tok_out  = tok_r;
  assign diag_out = diag_r;
  assign left_out = left_r;

endmodule

/* rtl/lcs_array.sv */
// Chain of LCS cells; a token enters cell 0 and leaves the last cell.
// Depends on lcs_pkg and lcs_cell.
module lcs_array #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF,
  parameter int CNT_W   = $clog2(MAX_LEN + 1),
  parameter int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [lcs_pkg::SYM_W-1:0] wr_sym,
  input  logic [CNT_W-1:0]          first_len,
  input  lcs_pkg::lcs_tok_t         tok_in,
  output lcs_pkg::lcs_tok_t         tok_out,
  output logic [CNT_W-1:0]          left_out
);

  lcs_pkg::lcs_tok_t tok_w  [0:MAX_LEN];
  logic [CNT_W-1:0]  diag_w [0:MAX_LEN];
  logic [CNT_W-1:0]  left_w [0:MAX_LEN];

  assign tok_w[0]  = tok_in;
  assign diag_w[0] = '0;
  assign left_w[0] = '0;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    lcs_cell #(
      .IDX     (g),
      .MAX_LEN (MAX_LEN),
      .CNT_W   (CNT_W),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_sym    (wr_sym),
      .first_len (first_len),
      .tok_in    (tok_w[g]),
      .diag_in   (diag_w[g]),
      .left_in   (left_w[g]),
      .tok_out   (tok_w[g+1]),
      .diag_out  (diag_w[g+1]),
      .left_out  (left_w[g+1])
    );
  end

  assign tok_out  = tok_w[MAX_LEN];
  assign left_out = left_w[MAX_LEN];

endmodule

/* rtl/longest_common_subsequence_length.sv */
// LCS length engine. First-string requests are taken back to back while idle.
// Second-string request: a token walks all MAX_LEN cells, one per cycle, and no
// new request is taken until it leaves the chain; on a last symbol the result
// goes to the output register, or is parked in HOLD while that register is still
// full, and input stays blocked while it is parked. Rate is set by the cell chain walk.
// Synchronous active-low reset clears the DP row, lengths and flags; the
// stored symbols are not reset.
module longest_common_subsequence_length #(
  parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lcs_pkg::lcs_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lcs_pkg::lcs_out_t out_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_LEN);

  // Controller: IDLE takes requests, RUN waits for the token to leave
  // the chain, HOLD parks a result while the output register is full.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] first_len_r, first_len_nxt;
  logic [CNT_W-1:0] second_len_r, second_len_nxt;
  logic             ovf_r, ovf_nxt;
  logic             first_done_r, first_done_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] hold_r, hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  lcs_pkg::lcs_out_t out_r, out_nxt;

  logic              acc;
  logic              slot_free;
  logic              clear;
  logic              wr_en;
  logic [CNT_W-1:0]  wr_pos;
  logic [IDX_W-1:0]  wr_idx;
  lcs_pkg::lcs_tok_t tok_in;
  lcs_pkg::lcs_tok_t tok_out;
  logic [CNT_W-1:0]  left_out;
  logic [CNT_W-1:0]  res_len;
  logic [CNT_W+lcs_pkg::LEN_W-1:0] res_ext;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Result length fitted to the 7-bit output field.
  assign res_len = (state_r == ST_HOLD) ? hold_r : left_out;
  assign res_ext = {{lcs_pkg::LEN_W{1'b0}}, res_len};

  // First-string write slot restarts at 0 when a new first string begins.
  assign wr_pos = first_done_r ? '0 : first_len_r;
  assign wr_idx = wr_pos[IDX_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    ovf_nxt        = ovf_r;
    first_done_nxt = first_done_r;
    last_nxt       = last_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    clear          = 1'b0;
    wr_en          = 1'b0;
    tok_in         = '0;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_data.operation == lcs_pkg::OP_FIRST) begin
            if (first_done_r) begin
              // new first string: drop row, lengths and flags
              clear          = 1'b1;
              second_len_nxt = '0;
              ovf_nxt        = 1'b0;
            end
            if (wr_pos < MAX_C) begin
              wr_en         = 1'b1;
              first_len_nxt = wr_pos + CNT_W'(1);
            end else begin
              first_len_nxt = wr_pos;
              ovf_nxt       = 1'b1;
            end
            first_done_nxt = in_data.last;
          end else begin
            first_done_nxt = 1'b1;
            tok_in.valid   = 1'b1;
            tok_in.sym     = in_data.symbol;
            tok_in.upd     = second_len_r < MAX_C;
            if (second_len_r < MAX_C) begin
              second_len_nxt = second_len_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            last_nxt  = in_data.last;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (tok_out.valid) begin
          if (!last_r) begin
            state_nxt = ST_IDLE;
          end else if (slot_free) begin
            out_valid_nxt         = 1'b1;
            out_nxt.match_length  = res_ext[lcs_pkg::LEN_W-1:0];
            out_nxt.truncated     = ovf_r;
            clear                 = 1'b1;
            second_len_nxt        = '0;
            state_nxt             = ST_IDLE;
          end else begin
            hold_nxt  = left_out;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.match_length = res_ext[lcs_pkg::LEN_W-1:0];
          out_nxt.truncated    = ovf_r;
          clear                = 1'b1;
          second_len_nxt       = '0;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      ovf_r        <= 1'b0;
      first_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      ovf_r        <= ovf_nxt;
      first_done_r <= first_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  lcs_array #(
    .MAX_LEN (MAX_LEN),
    .CNT_W   (CNT_W),
    .IDX_W   (IDX_W)
  ) u_array (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_sym    (in_data.symbol),
    .first_len (first_len_r),
    .tok_in    (tok_in),
    .tok_out   (tok_out),
    .left_out  (left_out)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // token launched into the chain leaves it after passing through every cell of the chain
  a_tok_latency: assert property (@(posedge clk) disable iff (!rst_n)
    tok_in.valid |-> ##MAX_LEN tok_out.valid)
    else $error("chain token latency mismatch");

  // a parked result only exists while the output register is occupied
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) |-> out_valid_r)
    else $error("hold state with empty output register");

  // LCS length never exceeds the stored first-string length
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tok_out.valid |-> (left_out <= first_len_r))
    else $error("LCS length exceeds first string length");

  // second-string counter stays within the store
  a_second_bound: assert property (@(posedge clk) disable iff (!rst_n)
    second_len_r <= MAX_C)
    else $error("second string count overflow");
`endif

endmodule
